### hw/rtl/ttdf_pkg.sv
`timescale 1ns / 1ps

package ttdf_pkg;

    // Channel count is tied to the named payload fields
    localparam int CHANNELS        = 3;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int RAW_W           = 16;
    localparam int TEMP_W          = 32;
    localparam int FILT_W          = 48;

    // Register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_GAIN          = 3'd0,
        REG_INTERCEPT     = 3'd1,
        REG_OFFSET_FIRST  = 3'd2,
        REG_OFFSET_SECOND = 3'd3,
        REG_OFFSET_THIRD  = 3'd4,
        REG_WEIGHT        = 3'd5
    } cfg_reg_t;

    localparam logic [23:0] GAIN_RST      = 24'd6318256;
    localparam logic [30:0] INTERCEPT_RST = 31'd49387891;
    localparam logic [31:0] WEIGHT_RST    = 32'd429497;

    // Limits in Q16.16
    localparam int HIGH_LIMIT = 200 * 65536;
    localparam int LOW_LIMIT  = 5 * 65536;
    localparam int NEAR_LIMIT = 2 * 65536;

    typedef struct packed {
        logic [RAW_W-1:0] raw_first;
        logic [RAW_W-1:0] raw_second;
        logic [RAW_W-1:0] raw_third;
    } smp_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_first;
        logic signed [TEMP_W-1:0] temp_second;
        logic signed [TEMP_W-1:0] temp_third;
        logic [CHANNELS-1:0]      updated_mask;
    } res_t;

endpackage

### hw/rtl/triple_temp_deglitch_filter.sv
`timescale 1ns / 1ps

// Three-channel temperature filter with spike rejection.
//
// Sample channel (smp_valid/smp_ready/smp_data): one beat carries one raw ADC
// sample per channel. Each sample is scaled to Q16.16 degrees, values outside
// 5..200 degrees are replaced by the current filtered value, and where the
// value lies within 2 degrees of the last converted value the channel's
// low-pass state moves towards it.
// Result channel (res_valid/res_ready/res_data): one beat per sample beat with
// the three filtered temperatures and the update mask.
// The channels share one multiply pipeline and one state memory; a sample
// beat is taken only once the previous beat's writebacks are done, so a new
// sample beat is never taken while the previous one is still in flight.
// A finished result waits in the output register while the next sample beat
// is taken and processed; if the receiver stalls, that next result is held
// in the assembly registers and no further sample is taken until it moves on.
// Reset clears the filter state to zero and loads the register defaults. The
// APB port is always ready; the user must write registers only while the
// block is idle, and the block itself does not enforce this.

module triple_temp_deglitch_filter
    import ttdf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // sample channel
    input  logic              smp_valid,
    output logic              smp_ready,
    input  smp_t              smp_data,
    // result channel
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res_data,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PRODW   = 24 + SAMPLE_BITS;
    localparam int SCALE_W = SAMPLE_BITS + 16;
    localparam int TW      = ((SCALE_W > 31) ? SCALE_W : 31) + 2;
    localparam int DW      = FILT_W + 1;
    localparam int MW      = DW + 17;
    localparam int PW      = MW + 1;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
    localparam logic signed [TW-1:0] HIGH_T = TW'(HIGH_LIMIT);
    localparam logic signed [TW-1:0] LOW_T  = TW'(LOW_LIMIT);
    localparam logic signed [TEMP_W:0] NEAR_P = (TEMP_W+1)'(NEAR_LIMIT);
    localparam logic signed [TEMP_W:0] NEAR_N = -((TEMP_W+1)'(NEAR_LIMIT));

    // One state memory entry per channel
    typedef struct packed {
        logic signed [FILT_W-1:0] filt;
        logic signed [TEMP_W-1:0] prev;
    } ent_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [23:0]        gain_reg;
    logic [30:0]        intercept_reg;
    logic signed [24:0] off_reg [CHANNELS];
    logic [31:0]        weight_reg;

    logic     cfg_wr;
    cfg_reg_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = cfg_reg_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RST;
            intercept_reg <= INTERCEPT_RST;
            weight_reg    <= WEIGHT_RST;
            for (int i = 0; i < CHANNELS; i++)
            begin
                off_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_GAIN:          gain_reg      <= pwdata[23:0];
                REG_INTERCEPT:     intercept_reg <= pwdata[30:0];
                REG_OFFSET_FIRST:  off_reg[0]    <= pwdata[24:0];
                REG_OFFSET_SECOND: off_reg[1]    <= pwdata[24:0];
                REG_OFFSET_THIRD:  off_reg[2]    <= pwdata[24:0];
                REG_WEIGHT:        weight_reg    <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_GAIN:          prdata = {8'd0, gain_reg};
            REG_INTERCEPT:     prdata = {1'b0, intercept_reg};
            REG_OFFSET_FIRST:  prdata = {{7{off_reg[0][24]}}, off_reg[0]};
            REG_OFFSET_SECOND: prdata = {{7{off_reg[1][24]}}, off_reg[1]};
            REG_OFFSET_THIRD:  prdata = {{7{off_reg[2][24]}}, off_reg[2]};
            REG_WEIGHT:        prdata = weight_reg;
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control: issue counter, stage valids, busy and pending flags
    // ------------------------------------------------------------------
    smp_t            item_reg;
    logic            busy_reg;
    logic            pend_reg;
    logic            iss_act_reg;
    logic [CH_W-1:0] iss_ch_reg;
    logic            s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic            s4_vld_reg, s5_vld_reg, s6_vld_reg;
    logic [CH_W-1:0] s1_ch_reg, s2_ch_reg, s3_ch_reg;
    logic [CH_W-1:0] s4_ch_reg, s5_ch_reg, s6_ch_reg;
    logic            res_valid_reg;
    res_t            res_data_reg;
    logic            smp_take;
    logic            res_load;

    // busy from the sample beat until its result leaves the assembly regs
    assign smp_ready = !busy_reg;
    assign smp_take  = smp_valid & smp_ready;
    assign res_load  = pend_reg & (!res_valid_reg | res_ready);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            iss_act_reg   <= 1'b0;
            iss_ch_reg    <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            s5_vld_reg    <= 1'b0;
            s6_vld_reg    <= 1'b0;
            s1_ch_reg     <= '0;
            s2_ch_reg     <= '0;
            s3_ch_reg     <= '0;
            s4_ch_reg     <= '0;
            s5_ch_reg     <= '0;
            s6_ch_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (smp_take)
            begin
                busy_reg    <= 1'b1;
                iss_act_reg <= 1'b1;
                iss_ch_reg  <= '0;
            end
            else if (iss_act_reg)
            begin
                if (iss_ch_reg == LAST_CH)
                begin
                    iss_act_reg <= 1'b0;
                end
                iss_ch_reg <= iss_ch_reg + 1'b1;
            end

            s1_vld_reg <= iss_act_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s1_ch_reg  <= iss_ch_reg;
            s2_ch_reg  <= s1_ch_reg;
            s3_ch_reg  <= s2_ch_reg;
            s4_ch_reg  <= s3_ch_reg;
            s5_ch_reg  <= s4_ch_reg;
            s6_ch_reg  <= s5_ch_reg;

            // last channel written back: result complete
            if (s6_vld_reg && s6_ch_reg == LAST_CH)
            begin
                pend_reg <= 1'b1;
            end
            else if (res_load)
            begin
                pend_reg <= 1'b0;
                busy_reg <= 1'b0;
            end

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp_take)
        begin
            item_reg <= smp_data;
        end
    end

    // ------------------------------------------------------------------
    // State memory, one entry per channel; unwritten entries read as zero
    // ------------------------------------------------------------------
    ent_t                state_mem [CHANNELS];
    ent_t                rd_data_reg;
    logic                rd_vld_reg;
    logic [CHANNELS-1:0] ent_valid_reg;
    logic                wr_en;
    ent_t                wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[s6_ch_reg] <= wr_data;
        end
        if (iss_act_reg)
        begin
            rd_data_reg <= state_mem[iss_ch_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                ent_valid_reg[s6_ch_reg] <= 1'b1;
            end
            if (iss_act_reg)
            begin
                rd_vld_reg <= ent_valid_reg[iss_ch_reg];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: sample select and gain multiply
    // ------------------------------------------------------------------
    logic [RAW_W-1:0] raw_arr [CHANNELS];
    logic [PRODW-1:0] prod_reg;

    always_comb
    begin
        raw_arr[0] = item_reg.raw_first;
        raw_arr[1] = item_reg.raw_second;
        raw_arr[2] = item_reg.raw_third;
    end

    always_ff @(posedge clk)
    begin
        if (iss_act_reg)
        begin
            prod_reg <= PRODW'(gain_reg) * PRODW'(raw_arr[iss_ch_reg][SAMPLE_BITS-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: intercept and offset
    // ------------------------------------------------------------------
    logic signed [TW-1:0]     t_full;
    logic signed [TW-1:0]     s2_tfull_reg;
    logic signed [FILT_W-1:0] s2_f_reg;
    logic signed [TEMP_W-1:0] s2_prev_reg;
    logic signed [24:0]       off_sel;

    assign off_sel = off_reg[s1_ch_reg];
    assign t_full  = $signed({{(TW-SCALE_W){1'b0}}, prod_reg[PRODW-1:8]})
                   - $signed({{(TW-31){1'b0}}, intercept_reg})
                   - $signed({{(TW-25){off_sel[24]}}, off_sel});

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            s2_tfull_reg <= t_full;
            s2_f_reg     <= rd_vld_reg ? rd_data_reg.filt : '0;
            s2_prev_reg  <= rd_vld_reg ? rd_data_reg.prev : '0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: spike rejection, closeness test, filter error
    // ------------------------------------------------------------------
    logic                     oor;
    logic signed [TEMP_W-1:0] t_sel;
    logic signed [TEMP_W:0]   d_prev;
    logic signed [DW-1:0]     diff;
    logic signed [TEMP_W-1:0] s3_t_reg, s4_t_reg, s5_t_reg, s6_t_reg;
    logic signed [FILT_W-1:0] s3_f_reg, s4_f_reg, s5_f_reg, s6_f_reg;
    logic                     s3_near_reg, s4_near_reg, s5_near_reg, s6_near_reg;
    logic signed [DW-1:0]     s3_diff_reg, s4_diff_reg;

    assign oor    = (s2_tfull_reg > HIGH_T) || (s2_tfull_reg < LOW_T);
    assign t_sel  = oor ? s2_f_reg[FILT_W-1:16] : s2_tfull_reg[TEMP_W-1:0];
    assign d_prev = {t_sel[TEMP_W-1], t_sel} - {s2_prev_reg[TEMP_W-1], s2_prev_reg};
    assign diff   = {t_sel[TEMP_W-1], t_sel, 16'd0} - {s2_f_reg[FILT_W-1], s2_f_reg};

    // ------------------------------------------------------------------
    // Stages 3 to 5: weight multiply in two 16-bit halves, then recombine
    // ------------------------------------------------------------------
    logic signed [MW-1:0] w_lo;
    logic signed [MW-1:0] w_hi;
    logic signed [MW-1:0] s4_plo_reg, s5_plo_reg;
    logic signed [MW-1:0] s5_phi_reg;
    logic signed [PW-1:0] s6_part_reg;

    assign w_lo = MW'($signed({1'b0, weight_reg[15:0]}));
    assign w_hi = MW'($signed({1'b0, weight_reg[31:16]}));

    always_ff @(posedge clk)
    begin
        s3_t_reg    <= t_sel;
        s3_f_reg    <= s2_f_reg;
        s3_near_reg <= (d_prev < NEAR_P) && (d_prev > NEAR_N);
        s3_diff_reg <= diff;

        s4_t_reg    <= s3_t_reg;
        s4_f_reg    <= s3_f_reg;
        s4_near_reg <= s3_near_reg;
        s4_diff_reg <= s3_diff_reg;
        s4_plo_reg  <= MW'(s3_diff_reg) * w_lo;

        s5_t_reg    <= s4_t_reg;
        s5_f_reg    <= s4_f_reg;
        s5_near_reg <= s4_near_reg;
        s5_plo_reg  <= s4_plo_reg;
        s5_phi_reg  <= MW'(s4_diff_reg) * w_hi;

        s6_t_reg    <= s5_t_reg;
        s6_f_reg    <= s5_f_reg;
        s6_near_reg <= s5_near_reg;
        s6_part_reg <= PW'(s5_plo_reg >>> 16) + PW'(s5_phi_reg);
    end

    // ------------------------------------------------------------------
    // Stage 6: state update, writeback and result assembly
    // ------------------------------------------------------------------
    logic signed [PW-1:0]     step_full;
    logic signed [FILT_W-1:0] filt_next;
    logic signed [TEMP_W-1:0] acc_temp_reg [CHANNELS];
    logic [CHANNELS-1:0]      acc_mask_reg;

    assign step_full = s6_part_reg >>> 16;
    assign filt_next = s6_near_reg ? (s6_f_reg + step_full[FILT_W-1:0]) : s6_f_reg;
    assign wr_en     = s6_vld_reg;
    assign wr_data   = '{filt: filt_next, prev: s6_t_reg};

    always_ff @(posedge clk)
    begin
        if (s6_vld_reg)
        begin
            acc_temp_reg[s6_ch_reg] <= filt_next[FILT_W-1:16];
            acc_mask_reg[s6_ch_reg] <= s6_near_reg;
        end
        if (res_load)
        begin
            res_data_reg.temp_first   <= acc_temp_reg[0];
            res_data_reg.temp_second  <= acc_temp_reg[1];
            res_data_reg.temp_third   <= acc_temp_reg[2];
            res_data_reg.updated_mask <= acc_mask_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_take_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        smp_take |-> !(iss_act_reg || s1_vld_reg || s2_vld_reg || s3_vld_reg
                       || s4_vld_reg || s5_vld_reg || s6_vld_reg || pend_reg))
        else $error("sample beat taken while pipeline not drained");

    a_wb_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s6_vld_reg |-> busy_reg)
        else $error("state writeback outside a busy period");

    a_no_issue_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !(iss_act_reg || s1_vld_reg || s6_vld_reg))
        else $error("channel work while result pending");

    a_pend_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_reg) |-> ($past(s6_vld_reg) && $past(s6_ch_reg) == LAST_CH))
        else $error("result completed without last channel writeback");

endmodule

### bench/tb_triple_temp_deglitch_filter.sv
`timescale 1ns / 1ps

module tb_triple_temp_deglitch_filter;
    import ttdf_pkg::*;

    // Q16.16 limits, kept here rather than taken from the design package
    localparam longint TEMP_HIGH   = 200 * 65536;
    localparam longint TEMP_LOW    = 5 * 65536;
    localparam longint TEMP_NEAR   = 2 * 65536;
    localparam int     CYCLE_LIMIT = 400000;
    // First word past the register map; a write here must change nothing
    localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(6 * 4);

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              smp_valid = 1'b0;
    logic              smp_ready;
    smp_t              smp_data  = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    res_t              res_data;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Mirror of the calibration registers, loaded with the reset values
    longint cal_gain      = GAIN_RST;
    longint cal_intercept = INTERCEPT_RST;
    longint cal_offset [3] = '{0, 0, 0};
    longint cal_weight    = WEIGHT_RST;

    // Predicted filter state: Q16.32 low-pass value and last converted Q16.16 value
    longint filt_state [3] = '{0, 0, 0};
    longint last_temp  [3] = '{0, 0, 0};

    // Walking temperature per channel (Q16.16) used to build well-formed streams
    longint aim_temp [3] = '{100 * 65536, 100 * 65536, 100 * 65536};

    res_t awaited_readings [$];
    int   err_count   = 0;
    int   cycle_count = 0;
    bit   jitter_on   = 1'b1;
    int   stall_left  = 0;

    triple_temp_deglitch_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp_data  (smp_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: convert, reject spikes, step the low-pass where the new
    // value is strictly within 2 degrees of the last converted one.
    // ------------------------------------------------------------------
    function automatic res_t filter_sample(smp_t s);
        res_t   r;
        longint raw [3];
        longint t, d, diff, part, whi, wlo;
        int     c;
        raw[0] = s.raw_first;
        raw[1] = s.raw_second;
        raw[2] = s.raw_third;
        whi = cal_weight >> 16;
        wlo = cal_weight & 65535;
        r = '0;
        for (c = 0; c < 3; c++)
        begin
            // Q.24 product floored to Q16.16, then the exact subtraction
            t = ((cal_gain * raw[c]) >>> 8) - cal_intercept - cal_offset[c];
            // spike: fall back to the current filtered value, floored
            if (t > TEMP_HIGH || t < TEMP_LOW)
                t = filt_state[c] >>> 16;
            d = t - last_temp[c];
            if (d < TEMP_NEAR && d > -TEMP_NEAR)
            begin
                // weight split in halves so the product stays inside 64 bits
                diff = (t <<< 16) - filt_state[c];
                part = ((diff * wlo) >>> 16) + diff * whi;
                filt_state[c] += part >>> 16;
                r.updated_mask[c] = 1'b1;
            end
            last_temp[c] = t;
        end
        r.temp_first  = 32'(filt_state[0] >>> 16);
        r.temp_second = 32'(filt_state[1] >>> 16);
        r.temp_third  = 32'(filt_state[2] >>> 16);
        return r;
    endfunction

    // Raw count that lands at or just above a given Q16.16 temperature
    function automatic longint raw_for_temp(int ch, longint tq);
        longint num, r;
        if (cal_gain == 0)
            return $urandom_range(0, 65535);
        num = tq + cal_intercept + cal_offset[ch];
        if (num < 0)
            return 0;
        r = (num * 256 + cal_gain - 1) / cal_gain;
        return (r > 65535) ? 65535 : r;
    endfunction

    // Mostly a slow random walk inside the window (so the filter keeps
    // moving), with jumps, spikes, exact limits and raw noise mixed in.
    function automatic smp_t make_sample();
        smp_t   s;
        longint raw [3];
        int     c, pick;
        for (c = 0; c < 3; c++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                aim_temp[c] += longint'($urandom_range(0, 4 * 65536)) - 2 * 65536;
                if (aim_temp[c] > TEMP_HIGH) aim_temp[c] = TEMP_HIGH;
                if (aim_temp[c] < TEMP_LOW)  aim_temp[c] = TEMP_LOW;
                raw[c] = raw_for_temp(c, aim_temp[c]);
            end
            else if (pick < 80)
            begin
                aim_temp[c] = longint'($urandom_range(TEMP_LOW, TEMP_HIGH));
                raw[c] = raw_for_temp(c, aim_temp[c]);
            end
            else if (pick < 88)
                raw[c] = raw_for_temp(c, ($urandom_range(0, 1) ? 260 : -40) * 65536);
            else if (pick < 93)
            begin
                aim_temp[c] = $urandom_range(0, 1) ? TEMP_HIGH : TEMP_LOW;
                raw[c] = raw_for_temp(c, aim_temp[c]);
            end
            else
                raw[c] = $urandom_range(0, 65535);
        end
        s.raw_first  = raw[0][15:0];
        s.raw_second = raw[1][15:0];
        s.raw_third  = raw[2][15:0];
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && smp_valid && smp_ready)
            awaited_readings.push_back(filter_sample(smp_data));
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (awaited_readings.size() == 0)
            begin
                $error("result beat with no sample outstanding");
                err_count++;
            end
            else
            begin
                want = awaited_readings.pop_front();
                check_field("temp_first", want.temp_first, res_data.temp_first);
                check_field("temp_second", want.temp_second, res_data.temp_second);
                check_field("temp_third", want.temp_third, res_data.temp_third);
                check_field("updated_mask", 32'(want.updated_mask),
                            32'(res_data.updated_mask));
            end
        end
    end

    // Receiver: random stall bursts while jitter is on
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            res_ready <= 1'b0;
            stall_left--;
        end
        else if (jitter_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 10) - 1;
            res_ready <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic logic [ADDR_W-1:0] reg_addr(cfg_reg_t r);
        return {r, 2'b00};
    endfunction

    // APB write: setup, access, then idle; pready is tied high so it lands on
    // the access edge. Mirror follows the register widths.
    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (addr[ADDR_W-1:2])
            REG_GAIN:          cal_gain      = value[23:0];
            REG_INTERCEPT:     cal_intercept = value[30:0];
            REG_OFFSET_FIRST:  cal_offset[0] = longint'($signed(value[24:0]));
            REG_OFFSET_SECOND: cal_offset[1] = longint'($signed(value[24:0]));
            REG_OFFSET_THIRD:  cal_offset[2] = longint'($signed(value[24:0]));
            REG_WEIGHT:        cal_weight    = value;
            default:           ;
        endcase
    endtask

    task automatic write_calibration(logic [31:0] gain, logic [31:0] icpt,
                                     logic [31:0] off0, logic [31:0] off1,
                                     logic [31:0] off2, logic [31:0] weight);
        apb_write(reg_addr(REG_GAIN), gain);
        apb_write(reg_addr(REG_INTERCEPT), icpt);
        apb_write(reg_addr(REG_OFFSET_FIRST), off0);
        apb_write(reg_addr(REG_OFFSET_SECOND), off1);
        apb_write(reg_addr(REG_OFFSET_THIRD), off2);
        apb_write(reg_addr(REG_WEIGHT), weight);
    endtask

    // One sample beat; an optional random idle gap goes first
    task automatic send_sample(smp_t s);
        if (jitter_on && $urandom_range(0, 3) == 0)
        begin
            smp_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        smp_valid <= 1'b1;
        smp_data  <= s;
        do
            @(posedge clk);
        while (!smp_ready);
    endtask

    task automatic send_raw(int a, int b, int c);
        smp_t s;
        s.raw_first  = a[15:0];
        s.raw_second = b[15:0];
        s.raw_third  = c[15:0];
        send_sample(s);
    endtask

    // Drain all results, then give the writebacks time to retire so that
    // a register write cannot land mid-beat.
    task automatic wait_idle();
        smp_valid <= 1'b0;
        @(posedge clk);
        while (awaited_readings.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic run_random(int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            // stretches of 25 beats, about one in four without any idling
            if (i % 25 == 0)
                jitter_on = ($urandom_range(0, 3) != 0);
            send_sample(make_sample());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Half a degree per count, no intercept: raw 10 is exactly 5 degrees,
    // raw 400 exactly 200, and a step of 4 counts is exactly 2 degrees.
    task automatic test_directed();
        jitter_on = 1'b1;
        // bits above the register widths must be dropped: gain -> 2^23, intercept -> 0
        write_calibration(32'hFF80_0000, 32'h8000_0000, 0, 0, 0, 32'h8000_0000);
        // unmapped word: nothing may change
        apb_write(SPARE_ADDR, 32'hFFFF_FFFF);
        send_raw(0, 16'hFFFF, 9);     // all rejected: below, above, just below
        send_raw(10, 400, 8);         // both limits accepted, far from last value
        send_raw(12, 398, 401);       // 1 degree steps move; just above the top
        send_raw(16, 394, 402);       // exactly 2 degrees apart: no update
        send_raw(19, 395, 10);        // 1.5 and 0.5 degree steps
        send_raw(20, 396, 13);
        wait_idle();
        apb_write(reg_addr(REG_OFFSET_FIRST), 32'(16384));
        apb_write(reg_addr(REG_OFFSET_SECOND), 32'(-65536));
        apb_write(reg_addr(REG_OFFSET_THIRD), 32'(16777215));
        send_raw(21, 398, 530);
        send_raw(22, 399, 532);
        send_raw(16'hFFFF, 0, 16'hFFFF);
        wait_idle();
        apb_write(reg_addr(REG_OFFSET_THIRD), 32'(-16777216));   // third always rejected
        apb_write(reg_addr(REG_WEIGHT), 32'hFFFF_FFFF);
        send_raw(24, 401, 20);
        send_raw(26, 402, 22);
        wait_idle();
        apb_write(reg_addr(REG_WEIGHT), 32'h0);                  // filter frozen
        send_raw(27, 400, 24);
        send_raw(28, 399, 26);
        wait_idle();
    endtask

    task automatic test_default_calibration();
        write_calibration(GAIN_RST, INTERCEPT_RST, 0, 0, 0, WEIGHT_RST);
        run_random(90);
        wait_idle();
    endtask

    task automatic test_offsets_full_weight();
        apb_write(reg_addr(REG_OFFSET_FIRST), 32'(98304));
        apb_write(reg_addr(REG_OFFSET_SECOND), 32'(-3 * 65536));
        apb_write(reg_addr(REG_OFFSET_THIRD), 32'(16384));
        apb_write(reg_addr(REG_WEIGHT), 32'hFFFF_FFFF);
        run_random(90);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        write_calibration(32'h00FF_FFFF, 32'h7FFF_FFFF, 32'(16777215),
                          32'(-16777216), 0, 0);
        run_random(60);
        wait_idle();
    endtask

    // No gain: temperature set by the offset alone (inside, on the top limit, far out)
    task automatic test_zero_gain();
        write_calibration(0, 0, 32'(-10 * 65536), 32'(-200 * 65536),
                          32'(-16777216), $urandom);
        run_random(40);
        wait_idle();
    endtask

    // Random calibration with the window placed somewhere in the ADC range
    task automatic test_random_calibration();
        int     k;
        longint gain, centre, icpt;
        for (k = 0; k < 3; k++)
        begin
            gain   = $urandom_range(1 << 20, 24'hFF_FFFF);
            centre = $urandom_range(1000, 60000);
            icpt   = ((gain * centre) >>> 8) - 100 * 65536;
            if (icpt < 0)             icpt = 0;
            if (icpt > 32'h7FFF_FFFF) icpt = 32'h7FFF_FFFF;
            write_calibration(32'(gain), 32'(icpt),
                              32'($urandom_range(0, 16 * 65536) - 8 * 65536),
                              32'($urandom_range(0, 16 * 65536) - 8 * 65536),
                              32'($urandom_range(0, 16 * 65536) - 8 * 65536),
                              $urandom);
            run_random(70);
            wait_idle();
        end
    endtask

    // Back-to-back beats with no idling on either side
    task automatic test_steady_stream();
        int i;
        jitter_on = 1'b0;
        for (i = 0; i < 60; i++)
            send_sample(make_sample());
        wait_idle();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_default_calibration();
        test_offsets_full_weight();
        test_register_extremes();
        test_zero_gain();
        test_random_calibration();
        test_steady_stream();

        // late stray beats would show up here
        repeat (30) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/ttdf_pkg.sv
hw/rtl/triple_temp_deglitch_filter.sv
bench/tb_triple_temp_deglitch_filter.sv
